[sv/ttt_pkg.sv]
// shared types and constants of the tick timer table
// used by the interfaces, the controller, the datapath, the top level and the checker
// no dependencies
package ttt_pkg;

  // table size and field widths
  localparam int unsigned NumTimersDefault = 16;
  localparam int unsigned ActW             = 2;
  localparam int unsigned IdW              = 4;
  localparam int unsigned DurW             = 20;
  localparam int unsigned TimeW            = 22;
  localparam int unsigned StepW            = 10;

  // register port
  localparam int unsigned DataW   = 32;
  localparam int unsigned RegIdxW = 1;
  localparam int unsigned PAddrW  = RegIdxW + 2;

  localparam logic [RegIdxW-1:0] RegTickStep = 1'b0;
  localparam logic [StepW-1:0]   StepReset   = 10'd100;

  // operation codes of an input word
  typedef enum logic [ActW-1:0] {
    ACT_START   = 2'd0,
    ACT_STOP    = 2'd1,
    ACT_DESTROY = 2'd2,
    ACT_TICK    = 2'd3
  } action_e;

  // controller to datapath
  typedef struct packed {
    logic accept;
    logic scan;
    logic flush;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic is_tick;
    logic scan_done;
    logic pend_valid;
    logic out_free;
  } status_t;

endpackage

[sv/ttt_in_if.sv]
// input channel of the tick timer table: valid, ready and one command word
// depends on ttt_pkg
interface ttt_in_if;

  logic                       valid;
  logic                       ready;
  logic [ttt_pkg::ActW-1:0]   action;
  logic [ttt_pkg::IdW-1:0]    timer_id;
  logic [ttt_pkg::DurW-1:0]   duration;

  modport source (output valid, action, timer_id, duration, input ready);
  modport sink   (input valid, action, timer_id, duration, output ready);

endinterface

[sv/ttt_out_if.sv]
// output channel of the tick timer table: valid, ready and one expiry word
// depends on ttt_pkg
interface ttt_out_if;

  logic                     valid;
  logic                     ready;
  logic [ttt_pkg::IdW-1:0]  expired_id;
  logic                     last_expired;

  modport source (output valid, expired_id, last_expired, input ready);
  modport sink   (input valid, expired_id, last_expired, output ready);

endinterface

[sv/ttt_ctrl.sv]
// controller of the tick timer table: idle, table scan and final flush
// depends on ttt_pkg for the command and status structs
module ttt_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  input  ttt_pkg::status_t status_i,
  output ttt_pkg::cmd_t    cmd_o,
  output logic             in_ready_o
);

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_SCAN  = 3'b010,
    ST_FLUSH = 3'b100
  } state_e;

  state_e state_q, state_d;

  // next state and commands
  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          if (status_i.is_tick) begin
            state_d = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        cmd_o.scan = 1'b1;
        if (status_i.scan_done) begin
          state_d = ST_FLUSH;
        end
      end
      ST_FLUSH: begin
        // the held id is the final one of this tick
        if (status_i.pend_valid) begin
          if (status_i.out_free) begin
            cmd_o.flush = 1'b1;
            state_d     = ST_IDLE;
          end
        end else begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

[sv/ttt_datapath.sv]
// datapath of the tick timer table: flags, time-left memory, scan pipeline,
// held expiry, output register and the tick step register
// depends on ttt_pkg
module ttt_datapath #(
  parameter int unsigned NUM_TIMERS = ttt_pkg::NumTimersDefault
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  ttt_pkg::cmd_t                 cmd_i,
  output ttt_pkg::status_t              status_o,
  input  logic [ttt_pkg::ActW-1:0]      action_i,
  input  logic [ttt_pkg::IdW-1:0]       timer_id_i,
  input  logic [ttt_pkg::DurW-1:0]      duration_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [ttt_pkg::IdW-1:0]       expired_id_o,
  output logic                          last_expired_o,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [ttt_pkg::PAddrW-1:0]    paddr,
  input  logic [ttt_pkg::DataW-1:0]     pwdata,
  output logic [ttt_pkg::DataW-1:0]     prdata
);

  localparam int unsigned IdxW = $clog2(NUM_TIMERS);
  localparam int unsigned CntW = IdxW + 1;
  localparam int unsigned CmpW = ((IdxW > ttt_pkg::IdW) ? IdxW : ttt_pkg::IdW) + 1;

  logic [ttt_pkg::StepW-1:0] step_q;
  logic [NUM_TIMERS-1:0]     present_q;
  logic [NUM_TIMERS-1:0]     running_q;
  logic [ttt_pkg::TimeW-1:0] time_mem [NUM_TIMERS];
  logic [ttt_pkg::TimeW-1:0] rd_data_q;
  logic [CntW-1:0]           scan_cnt_q;
  logic                      proc_valid_q;
  logic [IdxW-1:0]           proc_idx_q;
  logic                      pend_valid_q;
  logic [ttt_pkg::IdW-1:0]   pend_id_q;
  logic                      out_valid_q;
  logic [ttt_pkg::IdW-1:0]   out_id_q;
  logic                      out_last_q;

  ttt_pkg::action_e          act;
  logic [CmpW-1:0]           id_wide;
  logic                      id_ok;
  logic [IdxW-1:0]           id_idx;
  logic                      op_write;
  logic [ttt_pkg::TimeW-1:0] step_ext;
  logic [ttt_pkg::TimeW-1:0] left;
  logic                      active;
  logic                      expire;
  logic                      out_free;
  logic                      blocked;
  logic                      advance;
  logic                      rd_en;
  logic                      emit_scan;
  logic [CmpW-1:0]           proc_wide;
  logic                      cfg_wr;

  // command decode and addressing
  assign act      = ttt_pkg::action_e'(action_i);
  assign id_wide  = CmpW'(timer_id_i);
  assign id_ok    = id_wide < CmpW'(NUM_TIMERS);
  assign id_idx   = id_wide[IdxW-1:0];
  assign op_write = cmd_i.accept && (act == ttt_pkg::ACT_START) && id_ok;

  // one entry of the scan: subtract the step, expire at zero or below
  assign step_ext  = ttt_pkg::TimeW'(step_q);
  assign left      = rd_data_q - step_ext;
  assign active    = present_q[proc_idx_q] & running_q[proc_idx_q];
  assign expire    = proc_valid_q && active && (rd_data_q <= step_ext);
  assign out_free  = !out_valid_q || out_ready_i;
  assign blocked   = expire && pend_valid_q && !out_free;
  assign advance   = cmd_i.scan && !blocked;
  assign rd_en     = advance && (scan_cnt_q != CntW'(NUM_TIMERS));
  assign emit_scan = advance && expire && pend_valid_q;
  assign proc_wide = CmpW'(proc_idx_q);

  // status back to the controller
  assign status_o.is_tick    = (act == ttt_pkg::ACT_TICK);
  assign status_o.scan_done  = (scan_cnt_q == CntW'(NUM_TIMERS)) && !proc_valid_q;
  assign status_o.pend_valid = pend_valid_q;
  assign status_o.out_free   = out_free;

  // time-left memory, one write and one registered read a cycle
  always_ff @(posedge clk_i) begin
    if (op_write) begin
      time_mem[id_idx] <= ttt_pkg::TimeW'(duration_i);
    end else if (advance && proc_valid_q && active) begin
      time_mem[proc_idx_q] <= left;
    end
    if (rd_en) begin
      rd_data_q <= time_mem[scan_cnt_q[IdxW-1:0]];
    end
  end

  // present and running flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      present_q <= '0;
      running_q <= '0;
    end else if (cmd_i.accept && id_ok) begin
      case (act)
        ttt_pkg::ACT_START: begin
          present_q[id_idx] <= 1'b1;
          running_q[id_idx] <= 1'b1;
        end
        ttt_pkg::ACT_STOP: begin
          if (present_q[id_idx]) begin
            running_q[id_idx] <= 1'b0;
          end
        end
        ttt_pkg::ACT_DESTROY: begin
          present_q[id_idx] <= 1'b0;
          running_q[id_idx] <= 1'b0;
        end
        default: begin
        end
      endcase
    end else if (advance && expire) begin
      present_q[proc_idx_q] <= 1'b0;
      running_q[proc_idx_q] <= 1'b0;
    end
  end

  // scan counter, read stage and the held expiry
  // an expired id waits here until the next expiry or the end of the scan
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scan_cnt_q   <= '0;
      proc_valid_q <= 1'b0;
      proc_idx_q   <= '0;
      pend_valid_q <= 1'b0;
      pend_id_q    <= '0;
    end else if (cmd_i.accept && status_o.is_tick) begin
      scan_cnt_q   <= '0;
      proc_valid_q <= 1'b0;
      pend_valid_q <= 1'b0;
    end else if (advance) begin
      proc_valid_q <= rd_en;
      if (rd_en) begin
        proc_idx_q <= scan_cnt_q[IdxW-1:0];
        scan_cnt_q <= scan_cnt_q + 1'b1;
      end
      if (expire) begin
        pend_valid_q <= 1'b1;
        pend_id_q    <= proc_wide[ttt_pkg::IdW-1:0];
      end
    end else if (cmd_i.flush) begin
      pend_valid_q <= 1'b0;
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (emit_scan || cmd_i.flush) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit_scan || cmd_i.flush) begin
      out_id_q   <= pend_id_q;
      out_last_q <= cmd_i.flush;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign expired_id_o   = out_id_q;
  assign last_expired_o = out_last_q;

  // tick step register
  assign cfg_wr = psel && penable && pwrite &&
                  (paddr[ttt_pkg::PAddrW-1:2] == ttt_pkg::RegTickStep);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= ttt_pkg::StepReset;
    end else if (cfg_wr) begin
      step_q <= pwdata[ttt_pkg::StepW-1:0];
    end
  end

  assign prdata = (paddr[ttt_pkg::PAddrW-1:2] == ttt_pkg::RegTickStep) ?
                  ttt_pkg::DataW'(step_q) : '0;

endmodule

[sv/tick_timer_table_core.sv]
// tick timer table: a table of one-shot timers addressed by timer id
//
// in_i carries command words (start, stop, destroy, tick); out_o carries one
// word per timer that expires on a tick, in ascending id order, with
// last_expired set on the final one. a tick with no expiry gives no word.
// the register port holds tick_step at byte address 0; pready is always high.
// start, stop and destroy leave the input ready, so the next word may follow
// at once. a tick keeps the input stalled while the scan reads the time-left
// memory one entry a cycle, except where an output stall meets a pending
// expiry word, and then while the held word is flushed.
// when the receiver stalls, the output register holds its word and the scan
// pauses at the next expiry; an item that gives no output is still taken.
// reset empties the table and loads tick_step with 100; time-left values
// are written by start and by the scan of running timers: no clearing needed.
// depends on ttt_pkg, ttt_in_if, ttt_out_if, ttt_ctrl and ttt_datapath
module tick_timer_table_core #(
  parameter int unsigned NUM_TIMERS = ttt_pkg::NumTimersDefault
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  ttt_in_if.sink                      in_i,
  ttt_out_if.source                   out_o,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [ttt_pkg::PAddrW-1:0]  paddr,
  input  logic [ttt_pkg::DataW-1:0]   pwdata,
  output logic [ttt_pkg::DataW-1:0]   prdata,
  output logic                        pready
);

  ttt_pkg::cmd_t    cmd;
  ttt_pkg::status_t status;
  logic             in_ready;

  assign in_i.ready = in_ready;
  assign pready     = 1'b1;

  // sequencing of idle, scan and flush
  ttt_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .status_i   (status),
    .cmd_o      (cmd),
    .in_ready_o (in_ready)
  );

  // table storage and scan
  ttt_datapath #(
    .NUM_TIMERS (NUM_TIMERS)
  ) u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .status_o       (status),
    .action_i       (in_i.action),
    .timer_id_i     (in_i.timer_id),
    .duration_i     (in_i.duration),
    .out_valid_o    (out_o.valid),
    .out_ready_i    (out_o.ready),
    .expired_id_o   (out_o.expired_id),
    .last_expired_o (out_o.last_expired),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata)
  );

endmodule

[sv/ttt_checker.sv]
// port-level checks of the tick timer table, bound to the top level
// depends on ttt_pkg and tick_timer_table_core
module ttt_checker (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       in_valid_i,
  input logic                       in_ready_i,
  input logic [ttt_pkg::ActW-1:0]   in_action_i,
  input logic                       out_valid_i,
  input logic                       out_ready_i,
  input logic [ttt_pkg::IdW-1:0]    out_id_i,
  input logic                       out_last_i
);

  // a stalled word stays put
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_id_i) && $stable(out_last_i))
    else $error("stalled expiry word changed");

  // a tick keeps the input stalled while the table is scanned
  a_tick_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i && (in_action_i == ttt_pkg::ACT_TICK) |=> !in_ready_i)
    else $error("input taken during a tick");

  // expiry words are only produced while a tick is in progress
  a_out_from_tick: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_i) |-> $past(!in_ready_i))
    else $error("expiry word outside a tick");

  // a word that is not last is followed by more words of the same tick
  a_more_follow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_ready_i && !out_last_i |=> out_valid_i || !in_ready_i)
    else $error("tick ended without a last word");

endmodule

bind tick_timer_table_core ttt_checker u_ttt_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .in_action_i (in_i.action),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .out_id_i    (out_o.expired_id),
  .out_last_i  (out_o.last_expired)
);
